@@ hdl/csb_pkg.sv @@
// shared types and constants for the counting semaphore bank
`timescale 1ns / 1ps
`default_nettype none
package csb_pkg;

    localparam int NUM_SEMAPHORES_DEF = 16;
    localparam int SLOTS_PER_SEM_DEF  = 16;
    localparam int PID_W              = 16;
    localparam int COUNT_W            = 10;
    localparam int COUNT_MAX          = 511;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_RELEASE = 2'd2,
        OP_QUERY   = 2'd3
    } csb_op_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [3:0]       sem_id;
        logic [PID_W-1:0] caller_pid;
        logic [7:0]       init_value;
    } csb_req_t;

    typedef struct packed {
        logic             granted;
        logic             blocked;
        logic             woken_valid;
        logic [PID_W-1:0] woken_pid;
        logic             caller_holds;
        logic             full_error;
    } csb_rsp_t;

endpackage
`default_nettype wire

@@ hdl/counting_semaphore_bank_core.sv @@
// counting semaphore bank: per-semaphore count, fifo wait queue and holder table
//
//  channel | ports                      | moves
//  --------+----------------------------+-------------------------------
//  s_      | s_valid s_ready s_data     | one request (csb_req_t)
//  m_      | m_valid m_ready m_data     | one result per request (csb_rsp_t)
//
// each request passes through the steps accept with row read, match/queue read, update and write back
// the update waits in the last step while an earlier result is still not taken
// a new request is accepted while the last result waits in the output register
// reset clears counts and holder tables through per-row valid bits, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module counting_semaphore_bank_core #(
    parameter int NUM_SEMAPHORES = csb_pkg::NUM_SEMAPHORES_DEF,
    parameter int SLOTS_PER_SEM  = csb_pkg::SLOTS_PER_SEM_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire csb_pkg::csb_req_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output csb_pkg::csb_rsp_t      m_data
);
    import csb_pkg::*;

    localparam int SEM_W  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int SLOT_W = $clog2(SLOTS_PER_SEM);
    localparam int ROW_W  = SLOTS_PER_SEM * PID_W;

    localparam logic signed [COUNT_W-1:0] CNT_ZERO = '0;
    localparam logic signed [COUNT_W-1:0] CNT_ONE  = COUNT_W'(1);
    localparam logic signed [COUNT_W-1:0] CNT_TOP  = COUNT_W'(COUNT_MAX);
    localparam logic signed [COUNT_W-1:0] CNT_FULL = COUNT_W'(-SLOTS_PER_SEM);
    localparam logic [SLOT_W-1:0]         SLOT_LAST = SLOT_W'(SLOTS_PER_SEM - 1);

    typedef struct packed {
        logic signed [COUNT_W-1:0] cnt;
        logic [SLOT_W-1:0]         head;
        logic [SLOT_W-1:0]         tail;
    } meta_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_META = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    meta_t             meta_mem [NUM_SEMAPHORES];
    logic [ROW_W-1:0]  hold_mem [NUM_SEMAPHORES];
    logic [PID_W-1:0]  wq_mem   [NUM_SEMAPHORES][SLOTS_PER_SEM];
    logic [NUM_SEMAPHORES-1:0] meta_vld_reg;
    logic [NUM_SEMAPHORES-1:0] hold_vld_reg;

    csb_req_t          req_reg;
    meta_t             meta_rd_reg;
    logic [ROW_W-1:0]  row_rd_reg;
    logic              meta_rdv_reg;
    logic              row_rdv_reg;
    meta_t             meta_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SLOTS_PER_SEM-1:0] zero_vec_reg;
    logic [SLOTS_PER_SEM-1:0] mine_vec_reg;
    logic [PID_W-1:0]  wq_rd_reg;
    logic              m_valid_reg;
    csb_rsp_t          m_data_reg;

    logic              accept;
    logic              proceed;
    logic [SEM_W-1:0]  in_addr;
    logic [SEM_W-1:0]  sem_addr;
    logic              in_range;
    logic              pid_nz;
    meta_t             meta_q;
    logic [ROW_W-1:0]  row_q;

    meta_t             meta_next;
    logic [ROW_W-1:0]  row_next;
    logic              meta_we;
    logic              row_we;
    logic              row_clr;
    logic              wq_we;
    csb_rsp_t          rsp_next;

    logic [8:0] in_ext;
    logic [8:0] sem_ext;
    assign in_ext   = 9'(s_data.sem_id);
    assign sem_ext  = 9'(req_reg.sem_id);
    assign in_addr  = in_ext[SEM_W-1:0];
    assign sem_addr = sem_ext[SEM_W-1:0];
    assign in_range = sem_ext < 9'(NUM_SEMAPHORES);
    assign pid_nz   = req_reg.caller_pid != '0;

    assign s_ready = state_reg == ST_IDLE;
    assign accept  = s_valid && s_ready;
    assign proceed = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_META;
            ST_META: state_next = ST_EXEC;
            ST_EXEC: if (proceed) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (proceed) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // row read at accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg      <= s_data;
            meta_rd_reg  <= meta_mem[in_addr];
            row_rd_reg   <= hold_mem[in_addr];
            meta_rdv_reg <= meta_vld_reg[in_addr];
            row_rdv_reg  <= hold_vld_reg[in_addr];
        end
    end

    assign meta_q = meta_rdv_reg ? meta_rd_reg : '0;
    assign row_q  = row_rdv_reg ? row_rd_reg : '0;

    // slot matches and head waiter read
    always_ff @(posedge aclk) begin
        if (state_reg == ST_META) begin
            meta_reg  <= meta_q;
            row_reg   <= row_q;
            wq_rd_reg <= wq_mem[sem_addr][meta_q.head];
            for (int i = 0; i < SLOTS_PER_SEM; i++) begin
                zero_vec_reg[i] <= row_q[i*PID_W +: PID_W] == '0;
                mine_vec_reg[i] <= row_q[i*PID_W +: PID_W] == req_reg.caller_pid;
            end
        end
    end

    always_comb begin
        logic [SLOTS_PER_SEM-1:0] zero_oh;
        logic [SLOTS_PER_SEM-1:0] mine_oh;
        logic [SLOTS_PER_SEM-1:0] mine_rest;
        logic [SLOTS_PER_SEM-1:0] f_oh;
        logic any_zero;
        logic any_mine;
        zero_oh   = zero_vec_reg & (~zero_vec_reg + 1'b1);
        mine_oh   = mine_vec_reg & (~mine_vec_reg + 1'b1);
        mine_rest = mine_vec_reg & ~mine_oh;
        any_zero  = |zero_vec_reg;
        any_mine  = |mine_vec_reg;
        f_oh      = any_zero ? zero_oh : mine_oh;
        meta_next = meta_reg;
        row_next  = row_reg;
        meta_we   = 1'b0;
        row_we    = 1'b0;
        row_clr   = 1'b0;
        wq_we     = 1'b0;
        rsp_next  = '0;
        if (in_range) begin
            case (req_reg.opcode)
                OP_INIT: begin
                    meta_we        = 1'b1;
                    row_clr        = 1'b1;
                    meta_next.cnt  = COUNT_W'(req_reg.init_value);
                    meta_next.head = '0;
                    meta_next.tail = '0;
                end
                OP_ACQUIRE: begin
                    if (pid_nz) begin
                        rsp_next.caller_holds = any_mine;
                        if (meta_reg.cnt <= CNT_ZERO) begin
                            if (meta_reg.cnt <= CNT_FULL) begin
                                rsp_next.full_error = 1'b1;
                            end else begin
                                wq_we            = 1'b1;
                                meta_we          = 1'b1;
                                meta_next.cnt    = meta_reg.cnt - CNT_ONE;
                                meta_next.tail   = (meta_reg.tail == SLOT_LAST) ? '0 :
                                                   meta_reg.tail + 1'b1;
                                rsp_next.blocked = 1'b1;
                            end
                        end else if (!any_zero) begin
                            rsp_next.full_error = 1'b1;
                        end else begin
                            for (int i = 0; i < SLOTS_PER_SEM; i++) begin
                                if (zero_oh[i]) begin
                                    row_next[i*PID_W +: PID_W] = req_reg.caller_pid;
                                end
                            end
                            row_we                = 1'b1;
                            meta_we               = 1'b1;
                            meta_next.cnt         = meta_reg.cnt - CNT_ONE;
                            rsp_next.granted      = 1'b1;
                            rsp_next.caller_holds = 1'b1;
                        end
                    end
                end
                OP_RELEASE: begin
                    if (pid_nz) begin
                        if (meta_reg.cnt < CNT_ZERO) begin
                            if (!(any_zero || any_mine)) begin
                                rsp_next.full_error = 1'b1;
                            end else begin
                                for (int i = 0; i < SLOTS_PER_SEM; i++) begin
                                    if (f_oh[i]) begin
                                        row_next[i*PID_W +: PID_W] = wq_rd_reg;
                                    end else if (mine_oh[i]) begin
                                        row_next[i*PID_W +: PID_W] = '0;
                                    end
                                end
                                row_we                = 1'b1;
                                meta_we               = 1'b1;
                                meta_next.cnt         = meta_reg.cnt + CNT_ONE;
                                meta_next.head        = (meta_reg.head == SLOT_LAST) ? '0 :
                                                        meta_reg.head + 1'b1;
                                rsp_next.woken_valid  = 1'b1;
                                rsp_next.woken_pid    = wq_rd_reg;
                                rsp_next.caller_holds = (|mine_rest) ||
                                                        (wq_rd_reg == req_reg.caller_pid);
                            end
                        end else begin
                            if (meta_reg.cnt < CNT_TOP) begin
                                meta_next.cnt = meta_reg.cnt + CNT_ONE;
                            end
                            for (int i = 0; i < SLOTS_PER_SEM; i++) begin
                                if (mine_oh[i]) begin
                                    row_next[i*PID_W +: PID_W] = '0;
                                end
                            end
                            row_we                = 1'b1;
                            meta_we               = 1'b1;
                            rsp_next.caller_holds = |mine_rest;
                        end
                    end
                end
                OP_QUERY: rsp_next.caller_holds = pid_nz && any_mine;
                default: rsp_next = '0;
            endcase
        end
    end

    // write back
    always_ff @(posedge aclk) begin
        if (proceed) begin
            m_data_reg <= rsp_next;
            if (meta_we) begin
                meta_mem[sem_addr] <= meta_next;
            end
            if (row_we) begin
                hold_mem[sem_addr] <= row_next;
            end
            if (wq_we) begin
                wq_mem[sem_addr][meta_reg.tail] <= req_reg.caller_pid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_vld_reg <= '0;
            hold_vld_reg <= '0;
        end else if (proceed) begin
            if (meta_we) begin
                meta_vld_reg[sem_addr] <= 1'b1;
            end
            if (row_clr) begin
                hold_vld_reg[sem_addr] <= 1'b0;
            end else if (row_we) begin
                hold_vld_reg[sem_addr] <= 1'b1;
            end
        end
    end

    a_outcome_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_data.granted, m_data.blocked,
                              m_data.woken_valid, m_data.full_error}))
        else $error("more than one outcome flagged");

    a_woken_pid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.woken_valid) |-> (m_data.woken_pid == '0))
        else $error("woken pid without wake");

    a_grant_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.granted) |-> m_data.caller_holds)
        else $error("grant without holder slot");

    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_META) ##1 (state_reg == ST_EXEC))
        else $error("request sequencing broken");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (proceed && meta_we) |-> (meta_next.cnt >= CNT_FULL && meta_next.cnt <= CNT_TOP))
        else $error("count out of range");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the counting semaphore bank core
`timescale 1ns / 1ps
module tb_top;
    import csb_pkg::*;

    localparam int NSEM  = 16;
    localparam int NSLOT = 16;
    localparam int STALL_LIMIT = 4000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    csb_req_t s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    csb_rsp_t m_data;

    int       errors = 0;
    bit       idle_on = 1'b1;
    int       quiet_cycles = 0;
    csb_rsp_t pending_rsp[$];

    int signed   sem_count[NSEM];
    logic [15:0] sem_waiters[NSEM][NSLOT];
    logic [3:0]  sem_head[NSEM];
    logic [3:0]  sem_tail[NSEM];
    logic [15:0] sem_holders[NSEM][NSLOT];

    counting_semaphore_bank_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int holder_index(int s, logic [15:0] pid);
        for (int i = 0; i < NSLOT; i++)
            if (sem_holders[s][i] == pid) return i;
        return -1;
    endfunction

    function automatic csb_rsp_t apply_request(csb_req_t r);
        csb_rsp_t o;
        int s;
        int mine;
        int f;
        logic [3:0] h;
        logic [15:0] w;
        o = '0;
        s = r.sem_id;
        if (r.opcode == OP_INIT) begin
            sem_count[s] = r.init_value;
            sem_head[s] = '0;
            sem_tail[s] = '0;
            for (int i = 0; i < NSLOT; i++) begin
                sem_waiters[s][i] = '0;
                sem_holders[s][i] = '0;
            end
        end else if (r.opcode == OP_ACQUIRE && r.caller_pid != 0) begin
            if (sem_count[s] <= 0) begin
                if (-sem_count[s] >= NSLOT) begin
                    o.full_error = 1'b1;
                end else begin
                    sem_waiters[s][sem_tail[s]] = r.caller_pid;
                    sem_tail[s] = sem_tail[s] + 1'b1;
                    sem_count[s]--;
                    o.blocked = 1'b1;
                end
            end else begin
                f = holder_index(s, 16'd0);
                if (f < 0) begin
                    o.full_error = 1'b1;
                end else begin
                    sem_holders[s][f] = r.caller_pid;
                    sem_count[s]--;
                    o.granted = 1'b1;
                end
            end
        end else if (r.opcode == OP_RELEASE && r.caller_pid != 0) begin
            mine = holder_index(s, r.caller_pid);
            if (sem_count[s] < 0) begin
                h = sem_head[s];
                f = holder_index(s, 16'd0);
                if (f < 0) f = mine;
                if (f < 0) begin
                    o.full_error = 1'b1;
                end else begin
                    w = sem_waiters[s][h];
                    if (mine >= 0) sem_holders[s][mine] = '0;
                    sem_holders[s][f] = w;
                    sem_waiters[s][h] = '0;
                    sem_head[s] = h + 1'b1;
                    sem_count[s]++;
                    o.woken_valid = 1'b1;
                    o.woken_pid = w;
                end
            end else begin
                if (sem_count[s] < COUNT_MAX) sem_count[s]++;
                if (mine >= 0) sem_holders[s][mine] = '0;
            end
        end
        if (r.caller_pid != 0 && holder_index(s, r.caller_pid) >= 0)
            o.caller_holds = 1'b1;
        return o;
    endfunction

    task automatic send_request(csb_op_t op, int s, int pid, int ival);
        csb_req_t r;
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        r.opcode = op;
        r.sem_id = s[3:0];
        r.caller_pid = pid[15:0];
        r.init_value = ival[7:0];
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_rsp.push_back(apply_request(r));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // receiver with random stall bursts
    initial begin
        int burst;
        forever begin
            @(posedge aclk);
            if (idle_on && burst == 0 && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 18);
            if (burst > 0) begin
                burst--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= aresetn;
            end
        end
    end

    always @(posedge aclk) begin
        csb_rsp_t exp_rsp;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_data);
                errors++;
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (m_data !== exp_rsp) begin
                    $display("%0t mismatch expected %h actual %h", $time, exp_rsp, m_data);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("counting_semaphore_bank_core verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(OP_QUERY, 0, 1, 0);
        send_request(OP_ACQUIRE, 0, 5, 0);
        send_request(OP_RELEASE, 15, 65535, 0);
        send_request(OP_INIT, 15, 0, 255);
        send_request(OP_ACQUIRE, 15, 65535, 0);
        send_request(OP_QUERY, 15, 65535, 0);
        send_request(OP_ACQUIRE, 15, 0, 0);
        send_request(OP_RELEASE, 15, 0, 0);
        send_request(OP_QUERY, 15, 0, 0);
        send_request(OP_RELEASE, 15, 65535, 0);
        send_request(OP_RELEASE, 15, 1234, 0);
        send_request(OP_INIT, 3, 0, 1);
        send_request(OP_ACQUIRE, 3, 10, 0);
        send_request(OP_ACQUIRE, 3, 11, 0);
        send_request(OP_ACQUIRE, 3, 12, 0);
        send_request(OP_RELEASE, 3, 10, 0);
        send_request(OP_RELEASE, 3, 99, 0);
        send_request(OP_QUERY, 3, 12, 0);
        send_request(OP_INIT, 3, 0, 0);
    endtask

    // queue overflow, holder table full, wake with full table, and count saturation at the top
    task automatic test_limits();
        send_request(OP_INIT, 7, 0, 0);
        for (int i = 0; i < NSLOT + 2; i++) send_request(OP_ACQUIRE, 7, 100 + i, 0);
        for (int i = 0; i < NSLOT + 2; i++) send_request(OP_RELEASE, 7, 200 + i, 0);
        send_request(OP_INIT, 8, 0, 20);
        for (int i = 0; i < NSLOT + 6; i++) send_request(OP_ACQUIRE, 8, 300 + i, 0);
        send_request(OP_RELEASE, 8, 999, 0);
        send_request(OP_RELEASE, 8, 300, 0);
        send_request(OP_INIT, 9, 0, 16);
        for (int i = 0; i < NSLOT + 3; i++) send_request(OP_ACQUIRE, 9, 400 + i, 0);
        send_request(OP_RELEASE, 9, 999, 0);
        send_request(OP_RELEASE, 9, 401, 0);
        send_request(OP_INIT, 10, 0, 255);
        for (int i = 0; i < 300; i++) send_request(OP_RELEASE, 10, 7, 0);
        send_request(OP_QUERY, 10, 7, 0);
        wait_drained();
    endtask

    task automatic test_random(int n);
        int op;
        int pid;
        for (int i = 0; i < n; i++) begin
            pid = ($urandom_range(0, 40) == 0) ? 0 :
                  (($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535)
                                                : $urandom_range(1, 24));
            op = $urandom_range(0, 30);
            if (op == 0)
                send_request(OP_INIT, $urandom_range(0, 15), $urandom_range(0, 65535),
                             $urandom_range(0, 4) == 0 ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 3));
            else if (op < 14)
                send_request(OP_ACQUIRE, $urandom_range(0, 15), pid, $urandom_range(0, 255));
            else if (op < 27)
                send_request(OP_RELEASE, $urandom_range(0, 15), pid, $urandom_range(0, 255));
            else
                send_request(OP_QUERY, $urandom_range(0, 15), pid, $urandom_range(0, 255));
        end
    endtask

    initial begin
        for (int s = 0; s < NSEM; s++) begin
            sem_count[s] = 0;
            sem_head[s] = '0;
            sem_tail[s] = '0;
            for (int i = 0; i < NSLOT; i++) begin
                sem_waiters[s][i] = '0;
                sem_holders[s][i] = '0;
            end
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_limits();
        test_random(700);
        wait_drained();
        test_random(300);
        idle_on = 1'b0;
        test_random(100);
        wait_drained();
        if (errors == 0)
            $display("counting_semaphore_bank_core verification clean");
        else
            $display("counting_semaphore_bank_core verification failed");
        $finish;
    end
endmodule

@@ sim.f @@
hdl/csb_pkg.sv
hdl/counting_semaphore_bank_core.sv
tb/tb_top.sv
